### sv/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Types and constants shared by the parts of the LZ word decompressor.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int WORD_W = 16;
  localparam int DIST_LSB = 5;
  localparam int COUNT_W = 5;
  localparam int RUN_W = 6;
  localparam int TOKEN_IDX_W = 5;
  localparam logic [TOKEN_IDX_W-1:0] LAST_TOKEN = 5'd31;
  localparam logic [RUN_W-1:0] COUNT_BIAS = 6'd2;

  typedef enum logic [1:0] {
    PH_LOW    = 2'd0,
    PH_HIGH   = 2'd1,
    PH_TOKENS = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ISSUE = 2'd1,
    BK_DATA  = 2'd2
  } back_state_t;

  typedef struct packed {
    logic              literal;
    logic              clear;
    logic              fin;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              last_run;
    logic              last_stream;
  } result_t;

endpackage

### sv/lzwd_fifo.sv
// ----------------------------------------------------------------------------
// lzwd_fifo
// Small synchronous first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lzwd_fifo #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### sv/lzwd_front.sv
// ----------------------------------------------------------------------------
// lzwd_front
// Parses the flag words and turns each token into a literal or copy command.
// ----------------------------------------------------------------------------
module lzwd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [lzwd_pkg::WORD_W-1:0] word,
  input  logic                        start,
  input  logic                        fin,
  output logic                        cmd_push,
  output lzwd_pkg::cmd_t              cmd
);

  lzwd_pkg::phase_t                   phase;
  lzwd_pkg::phase_t                   phase_next;
  lzwd_pkg::phase_t                   eff_phase;
  logic [lzwd_pkg::WORD_W-1:0]        flags_lo;
  logic [2*lzwd_pkg::WORD_W-1:0]      flags;
  logic [lzwd_pkg::TOKEN_IDX_W-1:0]   idx;
  logic                               clear_pending;

  // A start marker restarts the parse, so its word is always a low flag half.
  assign eff_phase = start ? lzwd_pkg::PH_LOW : phase;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (eff_phase)
        lzwd_pkg::PH_HIGH: begin
          phase_next = lzwd_pkg::PH_TOKENS;
        end
        lzwd_pkg::PH_TOKENS: begin
          phase_next = (idx == lzwd_pkg::LAST_TOKEN) ? lzwd_pkg::PH_LOW
                                                      : lzwd_pkg::PH_TOKENS;
        end
        default: begin
          phase_next = lzwd_pkg::PH_HIGH;
        end
      endcase
    end
  end

  always_comb begin
    cmd_push    = accept && (eff_phase == lzwd_pkg::PH_TOKENS);
    cmd.literal = flags[idx];
    cmd.clear   = clear_pending;
    cmd.fin     = fin;
    cmd.word    = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lzwd_pkg::PH_LOW;
      idx           <= '0;
      clear_pending <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept && start) begin
        clear_pending <= 1'b1;
      end else if (cmd_push) begin
        clear_pending <= 1'b0;
      end
      if (accept && (eff_phase == lzwd_pkg::PH_HIGH)) begin
        idx <= '0;
      end else if (cmd_push) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (eff_phase)
        lzwd_pkg::PH_HIGH: begin
          flags <= {word, flags_lo};
        end
        lzwd_pkg::PH_TOKENS: begin
          flags <= flags;
        end
        default: begin
          flags_lo <= word;
        end
      endcase
    end
  end

endmodule

### sv/lzwd_back.sv
// ----------------------------------------------------------------------------
// lzwd_back
// Executes literal and copy commands against the circular history memory.
// ----------------------------------------------------------------------------
module lzwd_back #(
  parameter int DEPTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  lzwd_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                out_full,
  output logic                out_push,
  output lzwd_pkg::result_t   out_data
);

  localparam int AW = $clog2(DEPTH);

  logic [lzwd_pkg::WORD_W-1:0] mem [DEPTH];

  lzwd_pkg::back_state_t       state;
  lzwd_pkg::back_state_t       state_next;
  logic [AW-1:0]               wp;
  logic [AW:0]                 fill;
  logic [AW-1:0]               distance;
  logic [lzwd_pkg::RUN_W-1:0]  remaining;
  logic                        fin;
  logic                        rd_ok;
  logic [lzwd_pkg::WORD_W-1:0] rdata;

  logic [AW-1:0]               wp_eff;
  logic [AW:0]                 fill_eff;
  logic [AW:0]                 fill_inc;
  logic [AW-1:0]               raddr;
  logic                        rd_en;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lzwd_pkg::WORD_W-1:0] mem_wdata;
  logic [lzwd_pkg::WORD_W-1:0] copy_word;
  logic                        last_copy;

  // Entries at or beyond the fill count were not written since the stream
  // started and read as zero, which stands in for clearing the memory.
  assign wp_eff    = cmd.clear ? '0 : wp;
  assign fill_eff  = cmd.clear ? '0 : fill;
  assign fill_inc  = (fill == (AW+1)'(DEPTH)) ? fill : fill + 1'b1;
  assign raddr     = wp - distance;
  assign copy_word = rd_ok ? rdata : '0;
  assign last_copy = (remaining == lzwd_pkg::RUN_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      lzwd_pkg::BK_IDLE: begin
        if (cmd_pop && !cmd.literal) begin
          state_next = lzwd_pkg::BK_ISSUE;
        end
      end
      lzwd_pkg::BK_ISSUE: begin
        if (!out_full) begin
          state_next = lzwd_pkg::BK_DATA;
        end
      end
      lzwd_pkg::BK_DATA: begin
        state_next = last_copy ? lzwd_pkg::BK_IDLE : lzwd_pkg::BK_ISSUE;
      end
      default: begin
        state_next = lzwd_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    out_push  = 1'b0;
    out_data  = '{data: cmd.word, last_run: 1'b1, last_stream: cmd.fin};
    mem_we    = 1'b0;
    mem_waddr = wp_eff;
    mem_wdata = cmd.word;
    rd_en     = 1'b0;
    case (state)
      lzwd_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.literal) begin
            if (!out_full) begin
              cmd_pop  = 1'b1;
              out_push = 1'b1;
              mem_we   = 1'b1;
            end
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      lzwd_pkg::BK_ISSUE: begin
        rd_en = !out_full;
      end
      lzwd_pkg::BK_DATA: begin
        out_push  = 1'b1;
        out_data  = '{data: copy_word, last_run: last_copy,
                      last_stream: fin && last_copy};
        mem_we    = 1'b1;
        mem_waddr = wp;
        mem_wdata = copy_word;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwd_pkg::BK_IDLE;
      wp    <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (state == lzwd_pkg::BK_IDLE && cmd_pop) begin
        if (cmd.literal) begin
          wp   <= wp_eff + 1'b1;
          fill <= cmd.clear ? (AW+1)'(1) : fill_inc;
        end else begin
          wp   <= wp_eff;
          fill <= fill_eff;
        end
      end else if (state == lzwd_pkg::BK_DATA) begin
        wp   <= wp + 1'b1;
        fill <= fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lzwd_pkg::BK_IDLE && cmd_pop && !cmd.literal) begin
      distance  <= AW'(cmd.word[lzwd_pkg::WORD_W-1:lzwd_pkg::DIST_LSB]);
      remaining <= {1'b0, cmd.word[lzwd_pkg::COUNT_W-1:0]} + lzwd_pkg::COUNT_BIAS;
      fin       <= cmd.fin;
    end else if (state == lzwd_pkg::BK_DATA) begin
      remaining <= remaining - 1'b1;
    end
    if (rd_en) begin
      rd_ok <= ({1'b0, raddr} < fill);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_data_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == lzwd_pkg::BK_DATA) |-> ($past(state) == lzwd_pkg::BK_ISSUE))
    else $error("copy data step without a read issue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(DEPTH))
    else $error("fill count beyond history depth");

  a_copy_ends: assert property (@(posedge clk) disable iff (rst)
    (state == lzwd_pkg::BK_DATA && last_copy) |=> (state == lzwd_pkg::BK_IDLE))
    else $error("copy did not finish after its last word");

endmodule

### sv/lz_word_decompressor.sv
// ----------------------------------------------------------------------------
// lz_word_decompressor
// LZ77 decompressor for streams of 16-bit words with a circular history.
// ----------------------------------------------------------------------------
// Input side is a queue: a compressed word with its start and end marks is
// taken when push is high and full is low. Results come out of a queue: the
// oldest decompressed word is on data_word while empty is low, and pop takes
// it. last_of_run marks the final word caused by one input word, and
// last_of_stream marks that word when the input carried the end mark.
// Flag words produce no results. A literal token is registered in the
// command queue and then in the result queue before it can be popped. The
// back end writes a literal to the history and the result queue as it takes
// the command; a back-reference picks up the command and then, for each
// copied word, reads and then writes the single history memory. Both wait
// while the result queue is full. A reference copies 2 to 33 words; its
// first word passes the pick-up, read and data steps to the result queue.
// A two-entry command queue parts the parser from the copy engine, so flag
// words are taken while a copy runs. When the receiver stalls, the result
// queue fills, the copy engine waits, and full rises once the command queue
// is full. Reset empties both queues and restarts the parse; the history
// needs no clearing pass, since a fill count makes unwritten entries read
// as zero both after reset and after a start mark.
// ----------------------------------------------------------------------------
module lz_word_decompressor #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] compressed_word,
  input  logic        start_of_stream,
  input  logic        end_of_stream,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] data_word,
  output logic        last_of_run,
  output logic        last_of_stream
);

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  logic              accept;
  logic              cmd_push;
  lzwd_pkg::cmd_t    cmd_in;
  lzwd_pkg::cmd_t    cmd_out;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              out_full;
  logic              out_push;
  lzwd_pkg::result_t res_in;
  lzwd_pkg::result_t res_out;

  assign accept = push && !full;

  lzwd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .word     (compressed_word),
    .start    (start_of_stream),
    .fin      (end_of_stream),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lzwd_fifo #(
    .WIDTH ($bits(lzwd_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  lzwd_back #(
    .DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (res_in)
  );

  lzwd_fifo #(
    .WIDTH ($bits(lzwd_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (res_in),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign data_word      = res_out.data;
  assign last_of_run    = res_out.last_run;
  assign last_of_stream = res_out.last_stream;

endmodule

### tb/sv/lzwd_result_checker.sv
// ----------------------------------------------------------------------------
// lzwd_result_checker
// Watches both queues of the LZ word decompressor and checks every result.
// ----------------------------------------------------------------------------
// Each accepted request is run through a predictor with its own history, write
// pointer and flag parse. The predicted words wait in order until the block
// hands out a result, which is then compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module lzwd_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] compressed_word,
  input  logic        start_of_stream,
  input  logic        end_of_stream,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] data_word,
  input  logic        last_of_run,
  input  logic        last_of_stream,
  output int          errors,
  output int          pending
);

  localparam int HIST_DEPTH = 2048;
  localparam int MAX_REPORTS = 10;

  logic [lzwd_pkg::WORD_W-1:0]      hist [HIST_DEPTH];
  logic [10:0]                      wr_ptr;
  logic [31:0]                      flags;
  logic [lzwd_pkg::TOKEN_IDX_W-1:0] tok_idx;
  lzwd_pkg::phase_t                 phase;
  lzwd_pkg::result_t                expected_words [$];

  task automatic restart_stream();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist[i] = '0;
    end
    wr_ptr = '0;
    flags = '0;
    tok_idx = '0;
    phase = lzwd_pkg::PH_LOW;
  endtask

  task automatic emit_word(input logic [lzwd_pkg::WORD_W-1:0] w, input logic run_end,
                           input logic fin);
    lzwd_pkg::result_t r;
    hist[wr_ptr] = w;
    wr_ptr = wr_ptr + 1'b1;
    r.data = w;
    r.last_run = run_end;
    r.last_stream = fin;
    expected_words.push_back(r);
  endtask

  task automatic predict_request(input logic [lzwd_pkg::WORD_W-1:0] w, input logic sos,
                                 input logic eos);
    logic [10:0]                distance;
    logic [10:0]                src;
    logic [lzwd_pkg::RUN_W-1:0] run_len;
    if (sos) restart_stream();
    case (phase)
      lzwd_pkg::PH_HIGH: begin
        flags[31:16] = w;
        phase = lzwd_pkg::PH_TOKENS;
        tok_idx = '0;
      end
      lzwd_pkg::PH_TOKENS: begin
        if (flags[tok_idx]) begin
          emit_word(w, 1'b1, eos);
        end else begin
          distance = w[lzwd_pkg::WORD_W-1:lzwd_pkg::DIST_LSB];
          run_len = {1'b0, w[lzwd_pkg::COUNT_W-1:0]} + lzwd_pkg::COUNT_BIAS;
          // The source is read after every write, so overlapping copies
          // repeat the words that were just produced.
          for (int i = 0; i < run_len; i++) begin
            src = wr_ptr - distance;
            emit_word(hist[src], i == run_len - 1, eos && (i == run_len - 1));
          end
        end
        if (tok_idx == lzwd_pkg::LAST_TOKEN) begin
          phase = lzwd_pkg::PH_LOW;
        end else begin
          tok_idx = tok_idx + 1'b1;
        end
      end
      default: begin
        flags = {16'h0000, w};
        phase = lzwd_pkg::PH_HIGH;
      end
    endcase
  endtask

  initial begin
    errors = 0;
    pending = 0;
    restart_stream();
  end

  always @(posedge clk) begin : watch
    lzwd_pkg::result_t want;
    if (rst) begin
      restart_stream();
      expected_words.delete();
      pending <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          if (errors < MAX_REPORTS) begin
            $display("unexpected result: data %h last_run %b last_stream %b",
                     data_word, last_of_run, last_of_stream);
          end
          errors = errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.data !== data_word || want.last_run !== last_of_run ||
              want.last_stream !== last_of_stream) begin
            if (errors < MAX_REPORTS) begin
              $display("mismatch: expected data %h last_run %b last_stream %b, got %h %b %b",
                       want.data, want.last_run, want.last_stream,
                       data_word, last_of_run, last_of_stream);
            end
            errors = errors + 1;
          end
        end
      end
      if (push && !full) predict_request(compressed_word, start_of_stream, end_of_stream);
      pending <= expected_words.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the LZ word decompressor.
// ----------------------------------------------------------------------------
// A short directed stream covers literals, overlapping and zero-distance
// copies, the longest distance and count, end marks on flag halves and a
// restart in mid group. Random streams of well-formed groups follow, mixed
// with cut streams, stray marks and noise. Both queues idle at random, and the
// receiver once holds off long enough to stall the input side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int END_WAIT = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] compressed_word = '0;
  logic        start_of_stream = 1'b0;
  logic        end_of_stream = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] data_word;
  logic        last_of_run;
  logic        last_of_stream;
  logic        hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          errors;
  int          pending;
  int          sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lz_word_decompressor uut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .compressed_word (compressed_word),
    .start_of_stream (start_of_stream),
    .end_of_stream   (end_of_stream),
    .empty           (empty),
    .pop             (pop),
    .data_word       (data_word),
    .last_of_run     (last_of_run),
    .last_of_stream  (last_of_stream)
  );

  lzwd_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .compressed_word (compressed_word),
    .start_of_stream (start_of_stream),
    .end_of_stream   (end_of_stream),
    .empty           (empty),
    .pop             (pop),
    .data_word       (data_word),
    .last_of_run     (last_of_run),
    .last_of_stream  (last_of_stream),
    .errors          (errors),
    .pending         (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] make_flags(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom | $urandom;
      2: return $urandom & $urandom;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [15:0] make_token(input logic literal);
    logic [10:0] distance;
    logic [4:0]  count;
    int          r;
    if (literal) return 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 9);
    if (r < 7) distance = 11'($urandom_range(1, 32));
    else if (r == 7) distance = '0;
    else distance = 11'($urandom_range(0, 2047));
    count = ($urandom_range(0, 4) < 3) ? 5'($urandom_range(0, 7))
                                       : 5'($urandom_range(0, 31));
    return {distance, count};
  endfunction

  task automatic send_word(input logic [15:0] w, input logic sos, input logic eos);
    int gap;
    push <= 1'b1;
    compressed_word <= w;
    start_of_stream <= sos;
    end_of_stream <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The receiver pops in bursts with random stalls, and takes one long hold
  // when the sender asks for it.
  initial begin
    int burst;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        pop <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      burst = $urandom_range(1, 40);
      pop <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int          stream_no;
    int          n_groups;
    int          n_words;
    int          cut;
    int          pos;
    bit          with_start;
    bit          done;
    bit          sos;
    bit          eos;
    logic [31:0] group_flags;
    logic [15:0] w;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Literals at both extremes, an overlapping copy of the longest count,
    // a zero-distance copy, the longest distance, and an end mark that the
    // parse runs past without a new start.
    send_word(16'h0063, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b1);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h003F, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h8001, 1'b0, 1'b1);
    send_word(16'h1234, 1'b0, 1'b0);
    send_word(16'h0062, 1'b0, 1'b1);
    // A restart in mid group, with the end mark on a flag half.
    send_word(16'h0001, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b1);
    send_word(16'hABCD, 1'b0, 1'b0);
    send_word(16'h0021, 1'b0, 1'b1);
    drain();

    stream_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (stream_no > 0 && $urandom_range(0, 7) == 0) begin
        n_words = $urandom_range(10, 30);
        for (int k = 0; k < n_words; k++) begin
          if (sent == HOLD_AT) hold_req <= 1'b1;
          send_word(16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0);
        end
      end else begin
        n_groups = (stream_no == 0) ? 5 : $urandom_range(1, 3);
        n_words = n_groups * 34;
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_words - 1) : n_words - 1;
        with_start = (stream_no == 0) || ($urandom_range(0, 5) != 0);
        pos = 0;
        done = 1'b0;
        for (int g = 0; g < n_groups && !done; g++) begin
          group_flags = make_flags((stream_no == 0) ? 2 : $urandom_range(0, 4));
          for (int k = 0; k < 34 && !done; k++) begin
            if (k == 0) w = group_flags[15:0];
            else if (k == 1) w = group_flags[31:16];
            else w = make_token(group_flags[k-2]);
            sos = (pos == 0 && with_start) || ($urandom_range(0, 99) == 0);
            eos = (pos == cut) || ($urandom_range(0, 49) == 0);
            if (sent == HOLD_AT) hold_req <= 1'b1;
            send_word(w, sos, eos);
            done = (pos == cut);
            pos++;
          end
        end
      end
      stream_no++;
      if (stream_no == 4) drain();
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("lz_word_decompressor regression: pass");
    end else begin
      $display("lz_word_decompressor regression: fail");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("lz_word_decompressor regression: fail");
    $finish;
  end

endmodule
